### design/pfl_pkg.sv
// Shared types and constants for the Phong fragment lighting pipeline.
// No dependencies; every other design file imports this package.
package pfl_pkg;

  // Fixed field widths of the fragment item
  localparam int NORM_W     = 16;
  localparam int CH_W       = 12;
  localparam int COLOUR_W   = 3 * CH_W;
  localparam int SHIN_W     = 8;
  localparam int FIXED_IN_W = 3 * NORM_W + 3 * COLOUR_W + SHIN_W;
  localparam int RGB_W      = 48;
  localparam int OUT_CH_W   = 16;

  // Q1.14 unit value
  localparam int Q14_ONE = 16384;

  // Direction normalizer formats
  localparam int MN_W       = 24;
  localparam int SUM_W      = 50;
  localparam int SQ_W       = 52;
  localparam int LEN_W      = 25;
  localparam int NUM_W      = 40;
  localparam int SQRT_STEPS = 25;
  localparam int DIV_STEPS  = 15;

  // Pipeline depths
  localparam int UNIT_LAT  = 5 + SQRT_STEPS + DIV_STEPS + 1;
  localparam int SHADE_LAT = 20;

  // Default material
  localparam logic [COLOUR_W-1:0] DEFAULT_COLOUR = 36'h800_800_800;
  localparam logic [SHIN_W-1:0]   DEFAULT_SHIN   = 8'd32;
  localparam logic [RGB_W-1:0]    RGB_RESET      = 48'h1000_1000_1000;

  typedef enum logic [2:0] {
    REG_LIGHT_X   = 3'd0,
    REG_LIGHT_Y   = 3'd1,
    REG_LIGHT_Z   = 3'd2,
    REG_EYE_X     = 3'd3,
    REG_EYE_Y     = 3'd4,
    REG_EYE_Z     = 3'd5,
    REG_LIGHT_RGB = 3'd6,
    REG_STRENGTHS = 3'd7
  } cfg_reg_t;

  // Unit vector, three signed Q1.14 components, x at index 0
  typedef logic [2:0][NORM_W-1:0] vec_t;

  // Per-fragment data that rides alongside the direction normalizers
  typedef struct packed {
    vec_t                norm;
    logic [COLOUR_W-1:0] ma;
    logic [COLOUR_W-1:0] md;
    logic [COLOUR_W-1:0] ms;
    logic [SHIN_W-1:0]   shin;
  } side_t;

endpackage

### design/pfl_sqrt.sv
// Pipelined floor square root, one result bit per stage.
// Depends on pfl_pkg.
module pfl_sqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [pfl_pkg::SUM_W-1:0]  x,
  output logic [pfl_pkg::LEN_W-1:0]  root
);
  import pfl_pkg::*;

  logic [SQ_W-1:0] xs [SQRT_STEPS];
  logic [SQ_W-1:0] rs [SQRT_STEPS];

  for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_step
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - s));
    logic [SQ_W-1:0] xin;
    logic [SQ_W-1:0] rin;
    logic [SQ_W-1:0] trial;
    if (s == 0) begin : g_first
      assign xin = SQ_W'(x);
      assign rin = '0;
    end else begin : g_next
      assign xin = xs[s-1];
      assign rin = rs[s-1];
    end
    assign trial = rin + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (xin >= trial) begin
          xs[s] <= xin - trial;
          rs[s] <= (rin >> 1) + BIT;
        end else begin
          xs[s] <= xin;
          rs[s] <= rin >> 1;
        end
      end
    end
  end

  assign root = rs[SQRT_STEPS-1][LEN_W-1:0];

endmodule

### design/pfl_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on pfl_pkg.
module pfl_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [pfl_pkg::NUM_W-1:0]     num,
  input  logic [pfl_pkg::LEN_W-1:0]     den,
  output logic [pfl_pkg::DIV_STEPS-1:0] quo
);
  import pfl_pkg::*;

  logic [NUM_W-1:0]     rem [DIV_STEPS];
  logic [LEN_W-1:0]     dd  [DIV_STEPS];
  logic [DIV_STEPS-1:0] qq  [DIV_STEPS];

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    localparam int B = DIV_STEPS - 1 - s;
    logic [NUM_W-1:0]     rin;
    logic [LEN_W-1:0]     din;
    logic [DIV_STEPS-1:0] qin;
    logic [NUM_W-1:0]     dsh;
    if (s == 0) begin : g_first
      assign rin = num;
      assign din = den;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem[s-1];
      assign din = dd[s-1];
      assign qin = qq[s-1];
    end
    assign dsh = NUM_W'(din) << B;
    always_ff @(posedge clk) begin
      if (en) begin
        dd[s] <= din;
        if (rin >= dsh) begin
          rem[s] <= rin - dsh;
          qq[s]  <= qin | (DIV_STEPS'(1) << B);
        end else begin
          rem[s] <= rin;
          qq[s]  <= qin;
        end
      end
    end
  end

  assign quo = qq[DIV_STEPS-1];

endmodule

### design/pfl_unitize.sv
// Direction normalizer: scale, sum of squares, square root and three divides.
// Depends on pfl_pkg, pfl_sqrt and pfl_div.
module pfl_unitize #(
  parameter int POSITION_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [2:0][POSITION_WIDTH:0]          vec,
  output pfl_pkg::vec_t                         u
);
  import pfl_pkg::*;

  localparam int MW = POSITION_WIDTH + 1;
  localparam int PB = $clog2(MW);
  localparam int LAST_DLY = SQRT_STEPS + DIV_STEPS;

  logic [2:0][MW-1:0]   m1, m2, abs_c;
  logic [MW-1:0]        top1, top_c;
  logic [2:0]           neg1, neg2, neg3, neg4, neg5;
  logic [PB-1:0]        p2, p_c;
  logic                 zero2, zero3, zero4, zero5;
  logic [2:0][MN_W-1:0] mn3, mn4, mn5, mn_c;
  logic [2:0][47:0]     sq4;
  logic [SUM_W-1:0]     sum5;
  logic [LEN_W-1:0]     len;

  logic [2:0][MN_W-1:0] mn_d   [SQRT_STEPS];
  logic [2:0]           neg_d  [LAST_DLY];
  logic                 zero_d [LAST_DLY];
  logic [2:0][DIV_STEPS-1:0] quo;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_c[i] = vec[i][MW-1] ? MW'(~vec[i] + 1'b1) : vec[i];
    end
    top_c = abs_c[0];
    if (abs_c[1] > top_c) top_c = abs_c[1];
    if (abs_c[2] > top_c) top_c = abs_c[2];
  end

  // Leading one of the largest magnitude
  always_comb begin
    p_c = '0;
    for (int b = 0; b < MW; b++) begin
      if (top1[b]) p_c = PB'(b);
    end
  end

  // Bring the largest magnitude into [2^23, 2^24)
  always_comb begin
    logic [MW+MN_W-2:0] wide;
    for (int i = 0; i < 3; i++) begin
      wide    = {m2[i], {(MN_W-1){1'b0}}} >> p2;
      mn_c[i] = wide[MN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg1[i] <= vec[i][MW-1];
      end
      m1    <= abs_c;
      top1  <= top_c;
      m2    <= m1;
      neg2  <= neg1;
      p2    <= p_c;
      zero2 <= (top1 == '0);
      mn3   <= mn_c;
      neg3  <= neg2;
      zero3 <= zero2;
      for (int i = 0; i < 3; i++) begin
        sq4[i] <= 48'(mn3[i]) * 48'(mn3[i]);
      end
      mn4   <= mn3;
      neg4  <= neg3;
      zero4 <= zero3;
      sum5  <= SUM_W'(sq4[0]) + SUM_W'(sq4[1]) + SUM_W'(sq4[2]);
      mn5   <= mn4;
      neg5  <= neg4;
      zero5 <= zero4;
    end
  end

  pfl_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .x    (sum5),
    .root (len)
  );

  // Hold the scaled components and flags while the root settles
  always_ff @(posedge clk) begin
    if (en) begin
      mn_d[0]   <= mn5;
      neg_d[0]  <= neg5;
      zero_d[0] <= zero5;
      for (int k = 1; k < SQRT_STEPS; k++) begin
        mn_d[k] <= mn_d[k-1];
      end
      for (int k = 1; k < LAST_DLY; k++) begin
        neg_d[k]  <= neg_d[k-1];
        zero_d[k] <= zero_d[k-1];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    logic [NUM_W-1:0] num;
    assign num = NUM_W'({mn_d[SQRT_STEPS-1][i], 14'd0}) + NUM_W'(len[LEN_W-1:1]);
    pfl_div u_div (
      .clk (clk),
      .en  (en),
      .num (num),
      .den (len),
      .quo (quo[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic [NORM_W-1:0] mag;
        mag = (quo[i] > DIV_STEPS'(Q14_ONE)) ? NORM_W'(Q14_ONE) : NORM_W'(quo[i]);
        if (zero_d[LAST_DLY-1]) begin
          u[i] <= '0;
        end else if (neg_d[LAST_DLY-1][i]) begin
          u[i] <= ~mag + 1'b1;
        end else begin
          u[i] <= mag;
        end
      end
    end
  end

endmodule

### design/pfl_shade.sv
// Shading pipeline: N.L, reflection, V.R, specular power and colour sum.
// Depends on pfl_pkg.
module pfl_shade (
  input  logic                                 clk,
  input  logic                                 en,
  input  pfl_pkg::side_t                       side,
  input  pfl_pkg::vec_t                        lu,
  input  pfl_pkg::vec_t                        vu,
  input  logic [pfl_pkg::RGB_W-1:0]            light_rgb,
  input  logic [pfl_pkg::RGB_W-1:0]            strengths,
  output logic [2:0][pfl_pkg::OUT_CH_W-1:0]    rgb
);
  import pfl_pkg::*;

  localparam int RW       = 40;
  localparam int CAR_LAST = 17;

  typedef struct packed {
    vec_t                norm;
    vec_t                lu;
    vec_t                vu;
    logic [COLOUR_W-1:0] ma;
    logic [COLOUR_W-1:0] md;
    logic [COLOUR_W-1:0] ms;
    logic [SHIN_W-1:0]   shin;
    logic [14:0]         diff;
  } carry_t;

  function automatic logic signed [RW-1:0] rnd14(input logic signed [RW-1:0] x);
    logic [RW-1:0] m;
    m = x[RW-1] ? (~x + 1'b1) : x;
    m = (m + RW'(8192)) >> 14;
    return x[RW-1] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [14:0] clamp_unit(input logic signed [RW-1:0] d);
    if (d < 0) return '0;
    if (d > RW'(Q14_ONE)) return 15'(Q14_ONE);
    return d[14:0];
  endfunction

  carry_t car [1:CAR_LAST];

  logic signed [31:0] prod1 [3];
  logic signed [33:0] sum2;
  logic signed [16:0] nl3;
  logic signed [32:0] p4 [3];
  logic signed [18:0] r5 [3];
  logic signed [34:0] q6 [3];
  logic signed [36:0] sum7;
  logic [14:0]        base8;
  logic [14:0]        pr [8];
  logic [14:0]        pb [8];
  logic [14:0]        spec17;
  logic [27:0]        a1 [3], d1 [3], s1 [3];
  logic [43:0]        a2 [3];
  logic [42:0]        d2 [3], s2 [3];
  logic [43:0]        a3 [3];
  logic [58:0]        d3 [3], s3 [3];

  logic signed [RW-1:0] nl_c, vr_c;
  logic signed [RW-1:0] rr_c [3];

  assign nl_c = rnd14(RW'(sum2));
  assign vr_c = rnd14(RW'(sum7));
  for (genvar i = 0; i < 3; i++) begin : g_refl
    assign rr_c[i] = rnd14(RW'(p4[i]) <<< 1);
  end

  // Carry side data down to the colour stages
  always_ff @(posedge clk) begin
    if (en) begin
      car[1].norm <= side.norm;
      car[1].lu   <= lu;
      car[1].vu   <= vu;
      car[1].ma   <= side.ma;
      car[1].md   <= side.md;
      car[1].ms   <= side.ms;
      car[1].shin <= side.shin;
      car[1].diff <= '0;
      for (int k = 2; k <= CAR_LAST; k++) begin
        car[k] <= car[k-1];
      end
      car[3].diff <= clamp_unit(nl_c);
    end
  end

  // Dot products and reflection
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod1[i] <= 32'($signed(side.norm[i])) * 32'($signed(lu[i]));
      end
      sum2 <= 34'(prod1[0]) + 34'(prod1[1]) + 34'(prod1[2]);
      nl3  <= nl_c[16:0];
      for (int i = 0; i < 3; i++) begin
        p4[i] <= 33'(nl3) * 33'($signed(car[3].norm[i]));
        r5[i] <= 19'(rr_c[i]) - 19'($signed(car[4].lu[i]));
        q6[i] <= 35'($signed(car[5].vu[i])) * 35'(r5[i]);
      end
      sum7  <= 37'(q6[0]) + 37'(q6[1]) + 37'(q6[2]);
      base8 <= clamp_unit(vr_c);
    end
  end

  // Square-and-multiply, one exponent bit per stage
  for (genvar j = 0; j < 8; j++) begin : g_pow
    logic [14:0] pin, bin;
    logic [29:0] mr, mb;
    if (j == 0) begin : g_first
      assign pin = 15'(Q14_ONE);
      assign bin = base8;
    end else begin : g_next
      assign pin = pr[j-1];
      assign bin = pb[j-1];
    end
    assign mr = (30'(pin) * 30'(bin) + 30'd8192) >> 14;
    assign mb = (30'(bin) * 30'(bin) + 30'd8192) >> 14;
    always_ff @(posedge clk) begin
      if (en) begin
        pr[j] <= car[8+j].shin[j] ? mr[14:0] : pin;
        pb[j] <= mb[14:0];
      end
    end
  end

  // Per-channel colour terms, red at index 0
  always_ff @(posedge clk) begin
    if (en) begin
      spec17 <= pr[7];
      for (int k = 0; k < 3; k++) begin
        logic [61:0] tot;
        logic [24:0] v;
        a1[k] <= 28'(strengths[47:32]) * 28'(car[16].ma[(2-k)*CH_W +: CH_W]);
        d1[k] <= 28'(strengths[31:16]) * 28'(car[16].md[(2-k)*CH_W +: CH_W]);
        s1[k] <= 28'(strengths[15:0])  * 28'(car[16].ms[(2-k)*CH_W +: CH_W]);
        a2[k] <= 44'(a1[k]) * 44'(light_rgb[(2-k)*16 +: 16]);
        d2[k] <= 43'(d1[k]) * 43'(car[17].diff);
        s2[k] <= 43'(s1[k]) * 43'(spec17);
        a3[k] <= a2[k];
        d3[k] <= 59'(d2[k]) * 59'(light_rgb[(2-k)*16 +: 16]);
        s3[k] <= 59'(s2[k]) * 59'(light_rgb[(2-k)*16 +: 16]);
        tot = (62'(a3[k]) << 14) + 62'(d3[k]) + 62'(s3[k]) + (62'(1) << 36);
        v   = tot[61:37];
        rgb[k] <= (v > 25'hFFFF) ? 16'hFFFF : v[15:0];
      end
    end
  end

endmodule

### design/phong_fragment_lighting.sv
// Top level of the Phong fragment lighting pipeline: config registers,
// entry stage, two direction normalizers, shading pipeline and output skid.
// Depends on pfl_pkg, pfl_unitize and pfl_shade.
//
//   channel | direction | handshake        | payload
//   --------+-----------+------------------+----------------------------------
//   s_*     | in        | s_tvalid/s_tready| fragment item (tdata), has_material (tuser)
//   m_*     | out       | m_tvalid/m_tready| lit colour item, red/green/blue
//   cfg_*   | in        | cfg_we           | register index and write data
//
// One item enters per cycle while the skid register is empty.
// The depth is set by the square root (25 stages) and the divides (15 stages)
// of the light and view normalizers, running side by side.
// rst clears the valid bits and the config registers to their defaults.
// A stall on m_tready parks one item in a skid register; the pipeline freezes
// while that register is full, so s_tready follows only registered state.
module phong_fragment_lighting #(
  parameter int POSITION_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  // frag_x, frag_y, frag_z, norm_x, norm_y, norm_z, ambient_rgb,
  // diffuse_rgb, specular_rgb, shininess (lowest first), zero fill
  input  logic [((3 * POSITION_WIDTH + pfl_pkg::FIXED_IN_W + 7) / 8) * 8 - 1:0] s_tdata,
  input  logic                        s_tuser,   // has_material
  input  logic                        s_tvalid,
  output logic                        s_tready,
  output logic [pfl_pkg::RGB_W-1:0]   m_tdata,   // red, green, blue (lowest first)
  output logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [pfl_pkg::RGB_W-1:0]   cfg_data
);
  import pfl_pkg::*;

  localparam int PW     = POSITION_WIDTH;
  localparam int MW     = PW + 1;
  localparam int OFF_N  = 3 * PW;
  localparam int OFF_A  = OFF_N + 3 * NORM_W;
  localparam int OFF_D  = OFF_A + COLOUR_W;
  localparam int OFF_S  = OFF_D + COLOUR_W;
  localparam int OFF_SH = OFF_S + COLOUR_W;
  localparam int LAST   = UNIT_LAT + SHADE_LAT;

  // Config registers
  logic [2:0][PW-1:0] light_p, eye_p;
  logic [RGB_W-1:0]   light_rgb, strengths;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_p   <= '0;
      eye_p     <= '0;
      light_rgb <= RGB_RESET;
      strengths <= RGB_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LIGHT_X:   light_p[0] <= cfg_data[PW-1:0];
        REG_LIGHT_Y:   light_p[1] <= cfg_data[PW-1:0];
        REG_LIGHT_Z:   light_p[2] <= cfg_data[PW-1:0];
        REG_EYE_X:     eye_p[0]   <= cfg_data[PW-1:0];
        REG_EYE_Y:     eye_p[1]   <= cfg_data[PW-1:0];
        REG_EYE_Z:     eye_p[2]   <= cfg_data[PW-1:0];
        REG_LIGHT_RGB: light_rgb  <= cfg_data;
        REG_STRENGTHS: strengths  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline advance: frozen only while the skid register holds an item
  logic en;
  logic skid_valid;
  logic [RGB_W-1:0] skid_data;

  assign en       = !skid_valid;
  assign s_tready = en;

  // Entry stage: direction vectors and material selection
  logic [2:0][MW-1:0] lv0, vv0;
  logic               vld [0:LAST];
  side_t              side_d [0:UNIT_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        lv0[i] <= MW'($signed(light_p[i])) - MW'($signed(s_tdata[i*PW +: PW]));
        vv0[i] <= MW'($signed(eye_p[i]))   - MW'($signed(s_tdata[i*PW +: PW]));
        side_d[0].norm[i] <= s_tdata[OFF_N + i*NORM_W +: NORM_W];
      end
      if (s_tuser) begin
        side_d[0].ma   <= s_tdata[OFF_A +: COLOUR_W];
        side_d[0].md   <= s_tdata[OFF_D +: COLOUR_W];
        side_d[0].ms   <= s_tdata[OFF_S +: COLOUR_W];
        side_d[0].shin <= s_tdata[OFF_SH +: SHIN_W];
      end else begin
        side_d[0].ma   <= DEFAULT_COLOUR;
        side_d[0].md   <= DEFAULT_COLOUR;
        side_d[0].ms   <= '0;
        side_d[0].shin <= DEFAULT_SHIN;
      end
      // Delay the per-fragment data to meet the normalizer outputs
      for (int k = 1; k <= UNIT_LAT; k++) begin
        side_d[k] <= side_d[k-1];
      end
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= LAST; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= s_tvalid;
      for (int k = 1; k <= LAST; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  vec_t lu, vu;

  pfl_unitize #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_light_dir (
    .clk (clk),
    .en  (en),
    .vec (lv0),
    .u   (lu)
  );

  pfl_unitize #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_view_dir (
    .clk (clk),
    .en  (en),
    .vec (vv0),
    .u   (vu)
  );

  logic [2:0][OUT_CH_W-1:0] rgb;

  pfl_shade u_shade (
    .clk       (clk),
    .en        (en),
    .side      (side_d[UNIT_LAT]),
    .lu        (lu),
    .vu        (vu),
    .light_rgb (light_rgb),
    .strengths (strengths),
    .rgb       (rgb)
  );

  logic [RGB_W-1:0] p_data;
  assign p_data = {rgb[2], rgb[1], rgb[0]};

  // Output register with one skid entry. While the pipeline advances its
  // last stage must land somewhere: in the output register if that frees
  // up, otherwise in the skid register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) begin
        m_tdata    <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= vld[LAST];
      m_tdata  <= p_data;
    end else if (vld[LAST]) begin
      skid_valid <= 1'b1;
      skid_data  <= p_data;
    end
  end

endmodule

### verif/testbench.sv
// Self-checking testbench for phong_fragment_lighting: one point light, one eye.
// Depends on pfl_pkg and the design files; predicts each lit colour in-line.
module testbench;
  import pfl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PW      = 16;
  localparam int TDATA_W = ((3 * PW + FIXED_IN_W + 7) / 8) * 8;
  localparam int DOG_MAX = 20000;
  localparam int SETTLE  = 100;

  // One fragment as it travels on the input stream
  typedef struct packed {
    logic [7:0]  sh;
    logic [35:0] ms;
    logic [35:0] md;
    logic [35:0] ma;
    logic [15:0] nz, ny, nx;
    logic [15:0] fz, fy, fx;
    logic        mat;
  } frag_t;

  typedef longint vec3_t [3];

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [TDATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [RGB_W-1:0] m_tdata;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [RGB_W-1:0] cfg_data = '0;

  // Shadow copy of the configuration registers
  logic [15:0] light_pos [3];
  logic [15:0] eye_pos [3];
  logic [47:0] light_colour = RGB_RESET;
  logic [47:0] strength_set = RGB_RESET;

  frag_t frag_queue [$];
  logic [47:0] colour_due [$];
  frag_t cur_frag;
  int errors = 0;
  logic hold_req = 1'b0;

  phong_fragment_lighting #(.POSITION_WIDTH(PW)) dut (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Round to nearest, halves away from zero
  function automatic longint round_off(longint x, int s);
    longint unsigned m;
    m = (x < 0) ? longint'(-x) : x;
    m = (m + (64'd1 << (s - 1))) >> s;
    return (x < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp_one(longint d);
    if (d < 0) return 0;
    if (d > Q14_ONE) return Q14_ONE;
    return d;
  endfunction

  // Normalize a direction to Q1.14 after scaling its top component to 24 bits
  function automatic void unit_dir(input vec3_t v, output vec3_t u);
    longint unsigned m [3];
    bit ng [3];
    longint unsigned top, sq, ln, q;
    top = 0;
    for (int i = 0; i < 3; i++) begin
      ng[i] = v[i] < 0;
      m[i] = ng[i] ? longint'(-v[i]) : v[i];
      if (m[i] > top) top = m[i];
    end
    if (top == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return;
    end
    while (top >= (64'd1 << 24)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      top = top >> 1;
    end
    while (top < (64'd1 << 23)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      top = top << 1;
    end
    sq = 0;
    for (int i = 0; i < 3; i++) sq = sq + m[i] * m[i];
    ln = isqrt(sq);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 14) + ln / 2) / ln;
      if (q > Q14_ONE) q = Q14_ONE;
      u[i] = ng[i] ? -longint'(q) : longint'(q);
    end
  endfunction

  // Lit colour of one fragment, packed red low, blue high
  function automatic logic [47:0] lit_colour(frag_t f);
    vec3_t nv, lv, vv, lu, vu, rv;
    longint nl, vr, diff, spec;
    longint unsigned base, pw, sum, val, lc, sa, sd, ss, ca, cd, cs;
    logic [35:0] ma, md, ms;
    logic [15:0] fp [3];
    logic [15:0] np [3];
    int ex;
    logic [47:0] res;
    fp[0] = f.fx; fp[1] = f.fy; fp[2] = f.fz;
    np[0] = f.nx; np[1] = f.ny; np[2] = f.nz;
    for (int i = 0; i < 3; i++) begin
      nv[i] = longint'($signed(np[i]));
      lv[i] = longint'($signed(light_pos[i])) - longint'($signed(fp[i]));
      vv[i] = longint'($signed(eye_pos[i])) - longint'($signed(fp[i]));
    end
    if (f.mat) begin
      ma = f.ma; md = f.md; ms = f.ms; ex = int'(f.sh);
    end else begin
      ma = DEFAULT_COLOUR; md = DEFAULT_COLOUR; ms = '0; ex = int'(DEFAULT_SHIN);
    end
    unit_dir(lv, lu);
    unit_dir(vv, vu);
    nl = round_off(nv[0] * lu[0] + nv[1] * lu[1] + nv[2] * lu[2], 14);
    diff = clamp_one(nl);
    for (int i = 0; i < 3; i++) rv[i] = round_off(2 * nl * nv[i], 14) - lu[i];
    vr = round_off(vu[0] * rv[0] + vu[1] * rv[1] + vu[2] * rv[2], 14);
    // Square-and-multiply power; a zero exponent gives exactly one
    base = clamp_one(vr);
    pw = Q14_ONE;
    while (ex != 0) begin
      if (ex & 1) pw = (pw * base + 8192) >> 14;
      base = (base * base + 8192) >> 14;
      ex = ex >> 1;
    end
    spec = pw;
    sa = strength_set[47:32];
    sd = strength_set[31:16];
    ss = strength_set[15:0];
    for (int k = 0; k < 3; k++) begin
      lc = (light_colour >> ((2 - k) * 16)) & 64'hFFFF;
      ca = (ma >> ((2 - k) * 12)) & 64'hFFF;
      cd = (md >> ((2 - k) * 12)) & 64'hFFF;
      cs = (ms >> ((2 - k) * 12)) & 64'hFFF;
      sum = ((sa * ca * lc) << 14) + sd * cd * longint'(diff) * lc
          + ss * cs * longint'(spec) * lc;
      val = (sum + (64'd1 << 36)) >> 37;
      res[k*16 +: 16] = (val > 64'hFFFF) ? 16'hFFFF : val[15:0];
    end
    return res;
  endfunction

  // ------------------------------------------------------------------ driver

  int gap = 0;
  bit calm = 1'b0;

  // Most gaps are zero or short, a few long; calm stretches have none
  function automatic int next_gap(bit no_idle);
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap <= 0;
    end else begin
      if (s_tvalid && s_tready) colour_due.push_back(lit_colour(cur_frag));
      if ($urandom_range(0, 149) == 0) calm <= ~calm;
      if (!s_tvalid || s_tready) begin
        if (gap > 0) begin
          gap <= gap - 1;
          s_tvalid <= 1'b0;
        end else if (frag_queue.size() != 0) begin
          // Offer the next item
          cur_frag = frag_queue.pop_front();
          s_tdata <= {4'b0, cur_frag[212:1]};
          s_tuser <= cur_frag.mat;
          s_tvalid <= 1'b1;
          gap <= next_gap(calm);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ----------------------------------------------------------------- monitor

  int stall = 0;
  bit held = 1'b0;

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    logic [47:0] want;
    if (rst) begin
      m_tready <= 1'b0;
      stall <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (colour_due.size() == 0) begin
          $display("unexpected colour item %h", m_tdata);
          errors++;
        end else begin
          want = colour_due.pop_front();
          if (m_tdata[15:0] !== want[15:0]) report_mismatch("red", m_tdata[15:0], want[15:0]);
          if (m_tdata[31:16] !== want[31:16])
            report_mismatch("green", m_tdata[31:16], want[31:16]);
          if (m_tdata[47:32] !== want[47:32])
            report_mismatch("blue", m_tdata[47:32], want[47:32]);
        end
      end
      // Hold off once for long enough that the skid register fills and stalls input
      if (stall > 0) begin
        stall <= stall - 1;
        m_tready <= 1'b0;
      end else if (hold_req && !held) begin
        held <= 1'b1;
        stall <= 400;
        m_tready <= 1'b0;
      end else if (calm || $urandom_range(0, 99) < 70) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (frag_queue.size() == 0 && colour_due.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= DOG_MAX) begin
      $display("timeout waiting for a handshake");
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------- stimulus

  task automatic write_reg(cfg_reg_t idx, logic [47:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      REG_LIGHT_X:   light_pos[0] = v[15:0];
      REG_LIGHT_Y:   light_pos[1] = v[15:0];
      REG_LIGHT_Z:   light_pos[2] = v[15:0];
      REG_EYE_X:     eye_pos[0] = v[15:0];
      REG_EYE_Y:     eye_pos[1] = v[15:0];
      REG_EYE_Z:     eye_pos[2] = v[15:0];
      REG_LIGHT_RGB: light_colour = v;
      REG_STRENGTHS: strength_set = v;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(logic [15:0] l0, logic [15:0] l1, logic [15:0] l2,
                           logic [15:0] e0, logic [15:0] e1, logic [15:0] e2,
                           logic [47:0] lrgb, logic [47:0] str);
    write_reg(REG_LIGHT_X, {32'h0, l0});
    write_reg(REG_LIGHT_Y, {32'h0, l1});
    write_reg(REG_LIGHT_Z, {32'h0, l2});
    write_reg(REG_EYE_X, {32'h0, e0});
    write_reg(REG_EYE_Y, {32'h0, e1});
    write_reg(REG_EYE_Z, {32'h0, e2});
    write_reg(REG_LIGHT_RGB, lrgb);
    write_reg(REG_STRENGTHS, str);
  endtask

  // Wait until every item is in and every colour is out, then let it settle
  task automatic drain();
    while (frag_queue.size() != 0 || s_tvalid || colour_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic frag_t make_frag(logic [15:0] fx, logic [15:0] fy, logic [15:0] fz,
                                      logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                                      logic mat, logic [35:0] ma, logic [35:0] md,
                                      logic [35:0] ms, logic [7:0] sh);
    frag_t f;
    f.fx = fx; f.fy = fy; f.fz = fz;
    f.nx = nx; f.ny = ny; f.nz = nz;
    f.mat = mat; f.ma = ma; f.md = md; f.ms = ms; f.sh = sh;
    return f;
  endfunction

  function automatic logic [15:0] rand_norm();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic logic [35:0] rand_colour();
    return 36'({$urandom(), $urandom()});
  endfunction

  function automatic frag_t rand_frag();
    frag_t f;
    int r;
    r = $urandom_range(0, 9);
    f.fx = 16'($urandom()); f.fy = 16'($urandom()); f.fz = 16'($urandom());
    // Pull some fragments close to the light so the shading is not flat
    if (r < 3) begin
      f.fx = light_pos[0] + 16'($urandom_range(0, 1023) - 512);
      f.fy = light_pos[1] + 16'($urandom_range(0, 1023) - 512);
      f.fz = light_pos[2] + 16'($urandom_range(0, 1023) - 512);
    end
    f.nx = rand_norm(); f.ny = rand_norm(); f.nz = rand_norm();
    if (r == 9) begin
      f.nx = 0; f.ny = 0; f.nz = 0;
      case ($urandom_range(0, 2))
        0: f.nx = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
        1: f.ny = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
        default: f.nz = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      endcase
    end
    f.mat = $urandom_range(0, 3) != 0;
    f.ma = rand_colour(); f.md = rand_colour(); f.ms = rand_colour();
    f.sh = 8'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 255) : $urandom_range(0, 8));
    return f;
  endfunction

  initial begin
    logic [15:0] lp [3];
    logic [15:0] ep [3];
    for (int i = 0; i < 3; i++) begin
      light_pos[i] = '0;
      eye_pos[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults: light and eye both at the origin
    frag_queue.push_back(make_frag(0, 0, 0, 16384, 0, 0, 1'b0, '0, '0, '0, 8'd0));
    frag_queue.push_back(make_frag(16'h0100, 16'h0200, 16'hFF00, 0, 0, 16384,
                                   1'b1, '1, '1, '1, 8'd1));
    drain();

    // Directed fragments around a nearby light and eye
    write_all(16'h0400, 16'h0600, 16'h0800, 16'hFC00, 16'h0200, 16'h0A00,
              48'h1000_0800_2000, 48'h0800_1000_1000);
    frag_queue.push_back(make_frag(16'h0400, 16'h0600, 16'h0800, 0, 16384, 0,
                                   1'b1, '1, '1, '1, 8'd8));
    frag_queue.push_back(make_frag(16'hFC00, 16'h0200, 16'h0A00, 0, 0, 16384,
                                   1'b1, '1, '1, '1, 8'd8));
    frag_queue.push_back(make_frag(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hC000, 16'hC000, 16'hC000,
                                   1'b1, '1, '1, '1, 8'd255));
    frag_queue.push_back(make_frag(16'h8000, 16'h8000, 16'h8000, 16384, 16384, 16384,
                                   1'b1, '1, '1, '1, 8'd2));
    frag_queue.push_back(make_frag(0, 0, 0, 0, 0, 16384, 1'b1, '1, '1, '1, 8'd0));
    frag_queue.push_back(make_frag(0, 0, 0, 0, 0, 0, 1'b1, '1, '1, '1, 8'd0));
    frag_queue.push_back(make_frag(0, 0, 0, 0, 16384, 0, 1'b1, '0, '0, '0, 8'd255));
    frag_queue.push_back(make_frag(0, 0, 0, 0, 16384, 0, 1'b0, '1, '1, '1, 8'd0));
    frag_queue.push_back(make_frag(0, 16'h0400, 0, 16'h2D41, 16'h2D41, 0,
                                   1'b1, 36'hFFF_000_800, 36'h800_FFF_000, 36'h000_800_FFF, 8'd1));
    frag_queue.push_back(make_frag(16'h0200, 0, 16'h0100, 0, 16'hC000, 0,
                                   1'b1, '1, '1, '1, 8'd32));
    frag_queue.push_back(make_frag(16'h0100, 16'h0100, 16'h0100, 16384, 0, 0,
                                   1'b1, 36'h555555555, 36'hAAAAAAAAA, 36'h555555555, 8'd128));
    frag_queue.push_back(make_frag(16'h0100, 16'h0100, 16'h0100, 16384, 0, 0,
                                   1'b1, 36'hAAAAAAAAA, 36'h555555555, 36'hAAAAAAAAA, 8'd127));
    drain();

    // Random phases; the first two pin the register extremes
    for (int p = 0; p < 8; p++) begin
      for (int i = 0; i < 3; i++) begin
        lp[i] = 16'($urandom());
        ep[i] = 16'($urandom());
        if ($urandom_range(0, 1) != 0) lp[i] = 16'($urandom_range(0, 4095) - 2048);
        if ($urandom_range(0, 1) != 0) ep[i] = 16'($urandom_range(0, 4095) - 2048);
      end
      if (p == 0)
        write_all(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, '1, '1);
      else if (p == 1)
        write_all(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, '0, '0);
      else
        write_all(lp[0], lp[1], lp[2], ep[0], ep[1], ep[2],
                  48'({$urandom(), $urandom()} & 48'h3FFF_3FFF_3FFF),
                  48'({$urandom(), $urandom()} & (($urandom_range(0, 1) != 0) ?
                                                  48'hFFFF_FFFF_FFFF : 48'h1FFF_1FFF_1FFF)));
      if (p == 3) hold_req <= 1'b1;
      for (int n = 0; n < 210; n++) frag_queue.push_back(rand_frag());
      drain();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
design/pfl_pkg.sv
design/pfl_sqrt.sv
design/pfl_div.sv
design/pfl_unitize.sv
design/pfl_shade.sv
design/phong_fragment_lighting.sv
verif/testbench.sv
